// ===== hw/rtl/gfpit_pkg.sv =====
// Shared types and constants for the geofence point-inside test.
// Used by gfpit_cfg, gfpit_ctrl, gfpit_dp and geofence_point_inside_test.
`default_nettype none

package gfpit_pkg;

  // Angles are signed fixed point, 2^-AngleFracBits degree per unit
  localparam int unsigned AngleFracBits = 22;
  localparam logic signed [31:0] Deg180    = 32'sd180 <<< AngleFracBits;
  localparam logic signed [31:0] DegNeg180 = -(32'sd180 <<< AngleFracBits);
  localparam logic signed [31:0] Deg360    = 32'sd360 <<< AngleFracBits;

  localparam int unsigned MinVertices   = 3;
  localparam int unsigned CfgIdxWidth   = 3;
  localparam int unsigned CfgDataWidth  = 32;

  localparam logic OpWrite = 1'b0;
  localparam logic OpQuery = 1'b1;

  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_BOUNDARY_MODE = 3'd0,
    CFG_VERTEX_COUNT  = 3'd1,
    CFG_RECT_TOP      = 3'd2,
    CFG_RECT_LEFT     = 3'd3,
    CFG_RECT_BOTTOM   = 3'd4,
    CFG_RECT_RIGHT    = 3'd5
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RECT,
    ST_FETCH,
    ST_DRAIN,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic               boundary_mode;
    logic [6:0]         vertex_count;
    logic signed [29:0] rect_top_lat;
    logic signed [30:0] rect_left_lon;
    logic signed [29:0] rect_bottom_lat;
    logic signed [30:0] rect_right_lon;
  } cfg_t;

  typedef struct packed {
    logic wr_en;      // store the vertex on the input ports
    logic load_pt;    // capture the query point, clear the tally
    logic rd_en;      // read one vertex
    logic rd_first;   // this read only primes the previous-vertex register
    logic emit_rect;  // deliver rectangle result
    logic emit_poly;  // deliver polygon result
  } ctrl_cmd_t;

  typedef struct packed {
    logic pipe_busy;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/gfpit_cfg.sv =====
// Configuration register file for the geofence test.
// Depends on gfpit_pkg for the register index codes and cfg_t.
`default_nettype none

module gfpit_cfg (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_valid_i,
  output logic                                      cfg_ready_o,
  input  wire logic [gfpit_pkg::CfgIdxWidth-1:0]    cfg_index_i,
  input  wire logic [gfpit_pkg::CfgDataWidth-1:0]   cfg_data_i,
  output gfpit_pkg::cfg_t                           cfg_o
);

  gfpit_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (gfpit_pkg::cfg_idx_e'(cfg_index_i))
        gfpit_pkg::CFG_BOUNDARY_MODE: cfg_d.boundary_mode   = cfg_data_i[0];
        gfpit_pkg::CFG_VERTEX_COUNT:  cfg_d.vertex_count    = cfg_data_i[6:0];
        gfpit_pkg::CFG_RECT_TOP:      cfg_d.rect_top_lat    = $signed(cfg_data_i[29:0]);
        gfpit_pkg::CFG_RECT_LEFT:     cfg_d.rect_left_lon   = $signed(cfg_data_i[30:0]);
        gfpit_pkg::CFG_RECT_BOTTOM:   cfg_d.rect_bottom_lat = $signed(cfg_data_i[29:0]);
        gfpit_pkg::CFG_RECT_RIGHT:    cfg_d.rect_right_lon  = $signed(cfg_data_i[30:0]);
        default: ;  // unmapped index, ignored
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{boundary_mode:   1'b0,
                 vertex_count:    7'(gfpit_pkg::MinVertices),
                 rect_top_lat:    '0,
                 rect_left_lon:   '0,
                 rect_bottom_lat: '0,
                 rect_right_lon:  '0};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== hw/rtl/gfpit_ctrl.sv =====
// Controller FSM: accepts requests, sequences the vertex walk and result delivery.
// Depends on gfpit_pkg for state_e, cfg_t, ctrl_cmd_t and dp_status_t.
`default_nettype none

module gfpit_ctrl #(
  parameter int unsigned MAX_VERTICES = 64
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic                          op_i,
  output logic                               busy_o,
  input  wire gfpit_pkg::cfg_t               cfg_i,
  input  wire gfpit_pkg::dp_status_t         status_i,
  output gfpit_pkg::ctrl_cmd_t               cmd_o,
  output logic [$clog2(MAX_VERTICES)-1:0]    rd_addr_o
);

  localparam int unsigned AW = $clog2(MAX_VERTICES);
  localparam int unsigned CW = $clog2(MAX_VERTICES + 1);
  localparam int unsigned NW = (CW > 7) ? CW : 7;

  gfpit_pkg::state_e state_q, state_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [NW-1:0]     vc_ext, n_wide;
  logic [CW-1:0]     n_cnt;
  logic [AW-1:0]     last_addr;
  logic              fetch_done;

  // clamp the vertex count into [3, MAX_VERTICES]
  always_comb begin
    vc_ext = NW'(cfg_i.vertex_count);
    if (vc_ext < NW'(gfpit_pkg::MinVertices)) begin
      n_wide = NW'(gfpit_pkg::MinVertices);
    end else if (vc_ext > NW'(MAX_VERTICES)) begin
      n_wide = NW'(MAX_VERTICES);
    end else begin
      n_wide = vc_ext;
    end
  end

  assign n_cnt      = CW'(n_wide);
  assign last_addr  = AW'(n_cnt - CW'(1));
  assign fetch_done = (cnt_q == n_cnt);
  // first read fetches the last vertex, then vertices 0..n-1
  assign rd_addr_o  = (cnt_q == '0) ? last_addr : AW'(cnt_q - CW'(1));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      gfpit_pkg::ST_IDLE: begin
        if (start_i && op_i == gfpit_pkg::OpQuery) begin
          state_d = cfg_i.boundary_mode ? gfpit_pkg::ST_FETCH : gfpit_pkg::ST_RECT;
        end
      end
      gfpit_pkg::ST_RECT:  state_d = gfpit_pkg::ST_IDLE;
      gfpit_pkg::ST_FETCH: begin
        if (fetch_done) state_d = gfpit_pkg::ST_DRAIN;
      end
      gfpit_pkg::ST_DRAIN: begin
        if (!status_i.pipe_busy) state_d = gfpit_pkg::ST_EMIT;
      end
      gfpit_pkg::ST_EMIT:  state_d = gfpit_pkg::ST_IDLE;
      default:             state_d = gfpit_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o  = '0;
    busy_o = 1'b1;
    unique case (state_q)
      gfpit_pkg::ST_IDLE: begin
        busy_o        = 1'b0;
        cmd_o.wr_en   = start_i && (op_i == gfpit_pkg::OpWrite);
        cmd_o.load_pt = start_i && (op_i == gfpit_pkg::OpQuery);
      end
      gfpit_pkg::ST_RECT:  cmd_o.emit_rect = 1'b1;
      gfpit_pkg::ST_FETCH: begin
        cmd_o.rd_en    = 1'b1;
        cmd_o.rd_first = (cnt_q == '0);
      end
      gfpit_pkg::ST_DRAIN: ;
      gfpit_pkg::ST_EMIT:  cmd_o.emit_poly = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_o.load_pt) begin
      cnt_d = '0;
    end else if (state_q == gfpit_pkg::ST_FETCH) begin
      cnt_d = cnt_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gfpit_pkg::ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/gfpit_dp.sv =====
// Datapath: vertex memory, rectangle test, four-stage edge crossing pipeline,
// crossing tally and result registers. Depends on gfpit_pkg.
`default_nettype none

module gfpit_dp #(
  parameter int unsigned MAX_VERTICES = 64
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire gfpit_pkg::ctrl_cmd_t          cmd_i,
  input  wire logic [$clog2(MAX_VERTICES)-1:0] rd_addr_i,
  input  wire gfpit_pkg::cfg_t               cfg_i,
  input  wire logic [5:0]                    vertex_slot_i,
  input  wire logic signed [29:0]            point_lat_i,
  input  wire logic signed [30:0]            point_lon_i,
  output gfpit_pkg::dp_status_t              status_o,
  output logic                               done_o,
  output logic                               inside_res_o,
  output logic [6:0]                         crossing_total_o
);

  localparam int unsigned AW = $clog2(MAX_VERTICES);
  localparam int unsigned CW = $clog2(MAX_VERTICES + 1);
  localparam int unsigned TW = (CW > 7) ? CW : 7;
  localparam int unsigned SW = (AW > 6) ? AW : 6;

  // ---------------- vertex memory: {lat, lon} ----------------
  logic [60:0]   mem [MAX_VERTICES];
  logic [60:0]   rd_data_q;
  logic [SW-1:0] slot_ext;
  logic          slot_ok;

  assign slot_ext = SW'(vertex_slot_i);
  assign slot_ok  = (32'(vertex_slot_i) < 32'(MAX_VERTICES));

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en && slot_ok) begin
      mem[slot_ext[AW-1:0]] <= {point_lat_i, point_lon_i};
    end
    if (cmd_i.rd_en) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  // ---------------- query point ----------------
  logic signed [29:0] pt_lat_q;
  logic signed [30:0] pt_lon_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_pt) begin
      pt_lat_q <= point_lat_i;
      pt_lon_q <= point_lon_i;
    end
  end

  // ---------------- rectangle test ----------------
  logic signed [31:0] rect_span;
  logic               lat_ok, lon_narrow, lon_wide, rect_in;

  assign rect_span  = 32'($signed(cfg_i.rect_left_lon)) - 32'($signed(cfg_i.rect_right_lon));
  assign lat_ok     = ($signed(cfg_i.rect_bottom_lat) < pt_lat_q) &&
                      (pt_lat_q < $signed(cfg_i.rect_top_lat));
  assign lon_narrow = ($signed(cfg_i.rect_left_lon) < pt_lon_q) &&
                      (pt_lon_q < $signed(cfg_i.rect_right_lon));
  assign lon_wide   = ($signed(cfg_i.rect_left_lon) < pt_lon_q) ||
                      (pt_lon_q < $signed(cfg_i.rect_right_lon));
  // box spanning the meridian when the left/right step is 180 degrees or more
  assign rect_in    = lat_ok && (((rect_span < gfpit_pkg::Deg180) &&
                                  (rect_span > gfpit_pkg::DegNeg180)) ? lon_narrow : lon_wide);

  // ---------------- read stage: previous vertex ----------------
  logic               rd_valid_q, first_q;
  logic signed [29:0] cur_lat, prev_lat_q;
  logic signed [30:0] cur_lon, prev_lon_q;

  assign cur_lat = $signed(rd_data_q[60:31]);
  assign cur_lon = $signed(rd_data_q[30:0]);

  always_ff @(posedge clk_i) begin
    if (rd_valid_q) begin
      prev_lat_q <= cur_lat;
      prev_lon_q <= cur_lon;
    end
  end

  // ---------------- stage 1: differences and side flags ----------------
  logic               v1_q;
  logic signed [31:0] iy_raw_q;
  logic signed [30:0] ix1_q;
  logic               s1_q, s2_q, same_side_q;
  logic signed [30:0] dlat1_q, dlat2_q;
  logic signed [31:0] dlon1_q, dlon2_q;

  always_ff @(posedge clk_i) begin
    iy_raw_q    <= 32'(cur_lon) - 32'(prev_lon_q);
    ix1_q       <= 31'(cur_lat) - 31'(prev_lat_q);
    s1_q        <= cur_lon > pt_lon_q;
    s2_q        <= prev_lon_q > pt_lon_q;
    same_side_q <= ((prev_lon_q > 31'sd0) && (pt_lon_q > 31'sd0)) ||
                   ((prev_lon_q < 31'sd0) && (pt_lon_q < 31'sd0));
    dlat1_q     <= 31'(pt_lat_q) - 31'(cur_lat);
    dlat2_q     <= 31'(pt_lat_q) - 31'(prev_lat_q);
    dlon1_q     <= 32'(pt_lon_q) - 32'(cur_lon);
    dlon2_q     <= 32'(pt_lon_q) - 32'(prev_lon_q);
  end

  // ---------------- stage 2: meridian wrap and anchor pick ----------------
  logic               v2_q;
  logic               wrap_hi, wrap_lo, wrapped, use_cur;
  logic signed [31:0] iy_w;
  logic signed [31:0] iy_q;
  logic signed [30:0] ix2_q, a_q;
  logic signed [31:0] b_q;
  logic               cand2_q;

  assign wrap_hi = iy_raw_q > gfpit_pkg::Deg180;
  assign wrap_lo = iy_raw_q < gfpit_pkg::DegNeg180;
  assign wrapped = wrap_hi || wrap_lo;
  assign iy_w    = wrap_hi ? (iy_raw_q - gfpit_pkg::Deg360) :
                   wrap_lo ? (iy_raw_q + gfpit_pkg::Deg360) : iy_raw_q;
  assign use_cur = wrapped && !same_side_q;

  always_ff @(posedge clk_i) begin
    iy_q    <= iy_w;
    ix2_q   <= ix1_q;
    a_q     <= use_cur ? dlat1_q : dlat2_q;
    b_q     <= use_cur ? dlon1_q : dlon2_q;
    cand2_q <= wrapped ? (s1_q == s2_q) : (s1_q != s2_q);
  end

  // ---------------- stage 3: cross products ----------------
  logic               v3_q;
  logic signed [62:0] lhs_q, rhs_q;
  logic               iy_pos_q, iy_neg_q, cand3_q;

  always_ff @(posedge clk_i) begin
    lhs_q    <= 63'(a_q) * 63'(iy_q);
    rhs_q    <= 63'(ix2_q) * 63'(b_q);
    iy_pos_q <= iy_q > 32'sd0;
    iy_neg_q <= iy_q < 32'sd0;
    cand3_q  <= cand2_q;
  end

  // ---------------- stage 4: compare and tally ----------------
  logic          hit;
  logic [TW-1:0] tally_q;

  assign hit = cand3_q && ((iy_pos_q && (lhs_q < rhs_q)) || (iy_neg_q && (lhs_q > rhs_q)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_valid_q <= 1'b0;
      first_q    <= 1'b0;
      v1_q       <= 1'b0;
      v2_q       <= 1'b0;
      v3_q       <= 1'b0;
      tally_q    <= '0;
    end else begin
      rd_valid_q <= cmd_i.rd_en;
      first_q    <= cmd_i.rd_first;
      v1_q       <= rd_valid_q && !first_q;
      v2_q       <= v1_q;
      v3_q       <= v2_q;
      if (cmd_i.load_pt) begin
        tally_q <= '0;
      end else if (v3_q && hit) begin
        tally_q <= tally_q + TW'(1);
      end
    end
  end

  assign status_o.pipe_busy = rd_valid_q || v1_q || v2_q || v3_q;

  // ---------------- result registers ----------------
  logic       done_q;
  logic       inside_q;
  logic [6:0] total_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.emit_rect || cmd_i.emit_poly;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_rect) begin
      inside_q <= rect_in;
      total_q  <= '0;
    end else if (cmd_i.emit_poly) begin
      inside_q <= tally_q[0];
      total_q  <= tally_q[6:0];
    end
  end

  assign done_o           = done_q;
  assign inside_res_o     = inside_q;
  assign crossing_total_o = total_q;

endmodule

`default_nettype wire

// ===== hw/rtl/geofence_point_inside_test.sv =====
// Geofence point-inside test: a write request stores a vertex in its accept cycle.
// Rectangle query: ST_RECT, then done_o pulses. Polygon query: ST_FETCH walks the n
// clamped vertices, ST_DRAIN waits for the pipeline, ST_EMIT, then done_o pulses; the
// walk reads one vertex per cycle from the vertex memory. busy drops as done_o shows,
// so the next request can be taken in that cycle. The receiver cannot stall.
// Reset (rst_ni low, async) clears control and config; vertex memory is not cleared.
`default_nettype none

module geofence_point_inside_test #(
  parameter int unsigned MAX_VERTICES = 64
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire logic                                 op_i,
  input  wire logic [5:0]                           vertex_slot_i,
  input  wire logic signed [29:0]                   point_lat_i,
  input  wire logic signed [30:0]                   point_lon_i,
  input  wire logic                                 cfg_valid_i,
  output logic                                      cfg_ready_o,
  input  wire logic [gfpit_pkg::CfgIdxWidth-1:0]    cfg_index_i,
  input  wire logic [gfpit_pkg::CfgDataWidth-1:0]   cfg_data_i,
  output logic                                      done_o,
  output logic                                      inside_res_o,
  output logic [6:0]                                crossing_total_o
);

  localparam int unsigned AW = $clog2(MAX_VERTICES);

  gfpit_pkg::cfg_t       cfg;
  gfpit_pkg::ctrl_cmd_t  cmd;
  gfpit_pkg::dp_status_t status;
  logic [AW-1:0]         rd_addr;

  gfpit_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  gfpit_ctrl #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .op_i      (op_i),
    .busy_o    (busy),
    .cfg_i     (cfg),
    .status_i  (status),
    .cmd_o     (cmd),
    .rd_addr_o (rd_addr)
  );

  gfpit_dp #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .rd_addr_i        (rd_addr),
    .cfg_i            (cfg),
    .vertex_slot_i    (vertex_slot_i),
    .point_lat_i      (point_lat_i),
    .point_lon_i      (point_lon_i),
    .status_o         (status),
    .done_o           (done_o),
    .inside_res_o     (inside_res_o),
    .crossing_total_o (crossing_total_o)
  );

  // results are single-cycle strobes
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |=> !done_o)
    else $error("done_o held for more than one cycle");

  // a result only shows once the controller is back to idle
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> !busy)
    else $error("result delivered while busy");

  // only a query request makes the block busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   $rose(busy) |-> $past(start && (op_i == gfpit_pkg::OpQuery)))
    else $error("busy without an accepted query");

  // a vertex write never yields a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (start && !busy && (op_i == gfpit_pkg::OpWrite)) |=> !done_o)
    else $error("result after a vertex write");

endmodule

`default_nettype wire
